// ===== hdl/gaas_pkg.sv =====
// ----------------------------------------------------------------------------
// gaas_pkg
// Shared types, constants and helpers for the affine-gap global alignment
// score engine.
// ----------------------------------------------------------------------------
package gaas_pkg;

  // Score width on the stored column and the width used inside a cell.
  localparam int SCORE_W = 32;
  localparam int CALC_W  = 34;
  localparam int CODE_W  = 5;
  localparam int SUB_W   = 8;
  localparam int PEN_W   = 8;

  // Negative-infinity sentinel and the upper cap.
  localparam logic signed [CALC_W-1:0] NEG_INF = -(CALC_W'(64'sd1073741824));
  localparam logic signed [CALC_W-1:0] POS_MAX = CALC_W'(64'sd2147483647);

  // Input commands, carried in tuser.
  typedef enum logic [1:0] {
    CMD_LOAD_SUB   = 2'd0,
    CMD_LOAD_QUERY = 2'd1,
    CMD_DB_RESIDUE = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_OPEN   = 1'b0,
    REG_EXTEND = 1'b1
  } reg_idx_t;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // Token handed from one cell to the next.
  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] diag;
    logic signed [SCORE_W-1:0] up;
    logic signed [SCORE_W-1:0] vgap;
    logic signed [SCORE_W-1:0] bound;
  } wave_t;

  // Floor at negative infinity, cap at the largest 32-bit value.
  function automatic logic signed [SCORE_W-1:0] clampv(input logic signed [CALC_W-1:0] v);
    logic signed [CALC_W-1:0] t;
    t = v;
    if (v < NEG_INF) t = NEG_INF;
    if (v > POS_MAX) t = POS_MAX;
    return t[SCORE_W-1:0];
  endfunction

  function automatic logic signed [CALC_W-1:0] max2(input logic signed [CALC_W-1:0] a,
                                                     input logic signed [CALC_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hdl/global_alignment_affine_gap_score.sv =====
// ----------------------------------------------------------------------------
// global_alignment_affine_gap_score
// Affine-gap global alignment score engine built on a row of query cells.
// ----------------------------------------------------------------------------
// Load the substitution table (tuser 0) and the query (tuser 1) first. A
// database residue (tuser 2) starts one token that walks the row of
// MAX_QUERY cells, one cell per cycle, so each database residue occupies
// the engine from its acceptance until its token leaves the last cell,
// whatever the query length. A residue marked with tlast then passes
// through a done state while its score moves into the output register, and
// it holds the input off for as long as an earlier score still waits there.
// The engine keeps taking input while one score waits on the output channel.
// ----------------------------------------------------------------------------
module global_alignment_affine_gap_score #(
  parameter int MAX_QUERY     = 256,
  parameter int ALPHABET_SIZE = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // row_code[4:0], col_code[9:5], sub_score[17:10], residue[22:18], zero[23]
  input  logic [23:0] in_tdata,
  // command[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // score[31:0]
  output logic [31:0] out_tdata
);

  localparam int LEN_W = $clog2(MAX_QUERY + 1);
  localparam int IDX_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int AW    = $clog2(ALPHABET_SIZE);
  localparam logic [LEN_W-1:0] MAXQ_L = LEN_W'(MAX_QUERY);

  // Input fields.
  logic [4:0] row_code, col_code, residue;
  logic [7:0] sub_score;
  logic       accept;
  assign row_code  = in_tdata[4:0];
  assign col_code  = in_tdata[9:5];
  assign sub_score = in_tdata[17:10];
  assign residue   = in_tdata[22:18];
  assign accept    = in_tvalid && in_tready;

  // Configuration registers.
  logic [7:0] open_r, ext_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 8'd10;
      ext_r  <= 8'd1;
    end else if (cfg_wr_en) begin
      case (gaas_pkg::reg_idx_t'(cfg_addr))
        gaas_pkg::REG_OPEN:   open_r <= cfg_wr_data;
        gaas_pkg::REG_EXTEND: ext_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Control state.
  gaas_pkg::state_t                   state_r, state_nxt;
  logic [LEN_W-1:0]                   len_r;
  logic                               closed_r, first_r, last_r;
  logic signed [gaas_pkg::SCORE_W-1:0] top_r, score_r, up0;
  gaas_pkg::wave_t                    inj_r;
  gaas_pkg::wave_t                    waves [MAX_QUERY+1];
  logic                               out_tvalid_r;
  logic [31:0]                        out_tdata_r;
  logic [MAX_QUERY:0]                 wave_valids;
  logic                               is_sub, is_query, is_db, q_wr_en;
  logic [LEN_W-1:0]                   q_base;
  logic [ALPHABET_SIZE-1:0][gaas_pkg::SUB_W-1:0] column;

  assign is_sub   = accept && (gaas_pkg::cmd_t'(in_tuser) == gaas_pkg::CMD_LOAD_SUB);
  assign is_query = accept && (gaas_pkg::cmd_t'(in_tuser) == gaas_pkg::CMD_LOAD_QUERY);
  assign is_db    = accept && (gaas_pkg::cmd_t'(in_tuser) == gaas_pkg::CMD_DB_RESIDUE);
  assign q_base   = closed_r ? '0 : len_r;
  assign q_wr_en  = is_query && (q_base < MAXQ_L);

  // Top boundary for the new column.
  always_comb begin
    if (first_r) begin
      up0 = gaas_pkg::clampv(-gaas_pkg::CALC_W'({1'b0, open_r}));
    end else begin
      up0 = gaas_pkg::clampv(gaas_pkg::CALC_W'(top_r) - gaas_pkg::CALC_W'({1'b0, ext_r}));
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gaas_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      gaas_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (is_db) state_nxt = gaas_pkg::ST_RUN;
      end
      gaas_pkg::ST_RUN: begin
        if (waves[MAX_QUERY].valid) begin
          state_nxt = last_r ? gaas_pkg::ST_DONE : gaas_pkg::ST_IDLE;
        end
      end
      gaas_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) state_nxt = gaas_pkg::ST_IDLE;
      end
      default: state_nxt = gaas_pkg::ST_IDLE;
    endcase
  end

  // Query length, column flags and top boundary.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      closed_r <= 1'b0;
      first_r  <= 1'b1;
      top_r    <= '0;
    end else begin
      if (is_query) begin
        len_r    <= q_wr_en ? q_base + LEN_W'(1) : q_base;
        closed_r <= in_tlast;
        first_r  <= 1'b1;
        top_r    <= '0;
      end
      if (is_db) begin
        top_r <= up0;
      end
      if (state_r == gaas_pkg::ST_RUN && waves[MAX_QUERY].valid) begin
        first_r <= last_r;
        if (last_r) top_r <= '0;
      end
    end
  end

  // Token injected into the first cell and the result holding register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inj_r.valid <= 1'b0;
    end else begin
      inj_r.valid <= is_db;
    end
    if (is_db) begin
      inj_r.diag  <= top_r;
      inj_r.up    <= up0;
      inj_r.vgap  <= gaas_pkg::NEG_INF[gaas_pkg::SCORE_W-1:0];
      inj_r.bound <= gaas_pkg::clampv(-gaas_pkg::CALC_W'({1'b0, open_r}));
      last_r      <= in_tlast;
    end
    if (state_r == gaas_pkg::ST_RUN && waves[MAX_QUERY].valid) begin
      score_r <= waves[MAX_QUERY].up;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == gaas_pkg::ST_DONE && (!out_tvalid_r || out_tready)) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == gaas_pkg::ST_DONE && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= score_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Substitution table.
  gaas_sub_table #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_table (
    .clk     (clk),
    .wr_en   (is_sub && (32'(row_code) < ALPHABET_SIZE) && (32'(col_code) < ALPHABET_SIZE)),
    .wr_row  (row_code[AW-1:0]),
    .wr_col  (col_code[AW-1:0]),
    .wr_data (sub_score),
    .rd_en   (is_db),
    .rd_zero (!(32'(residue) < ALPHABET_SIZE)),
    .rd_col  (residue[AW-1:0]),
    .rd_data (column)
  );

  // Row of query cells.
  assign waves[0] = inj_r;
  genvar gi;
  generate
    for (gi = 0; gi < MAX_QUERY; gi++) begin : g_cell
      gaas_cell #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .LEN_W         (LEN_W),
        .IDX_W         (IDX_W),
        .IDX           (gi)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .query_len (len_r),
        .first_col (first_r),
        .open_pen  (open_r),
        .ext_pen   (ext_r),
        .column    (column),
        .q_wr_en   (q_wr_en),
        .q_wr_idx  (q_base[IDX_W-1:0]),
        .q_wr_code (residue),
        .wave_i    (waves[gi]),
        .wave_o    (waves[gi+1])
      );
    end
    for (gi = 0; gi <= MAX_QUERY; gi++) begin : g_valid
      assign wave_valids[gi] = waves[gi].valid;
    end
  endgenerate

  // Only one token is ever in flight along the row.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wave_valids))
    else $error("more than one token in the cell row");

  // A token leaves the row only while the sequencer waits for it.
  a_token_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    waves[MAX_QUERY].valid |-> state_r == gaas_pkg::ST_RUN)
    else $error("token left the cell row outside a run");

  // After a last-marked residue the next column starts from the corner.
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gaas_pkg::ST_DONE |-> first_r && top_r == '0)
    else $error("column state not rearmed after the final residue");

endmodule

// ===== hdl/gaas_sub_table.sv =====
// ----------------------------------------------------------------------------
// gaas_sub_table
// Substitution score memory, one word per database code holding the whole
// column over all query codes, with a registered column read.
// ----------------------------------------------------------------------------
module gaas_sub_table #(
  parameter int ALPHABET_SIZE = 24
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [$clog2(ALPHABET_SIZE)-1:0]         wr_row,
  input  logic [$clog2(ALPHABET_SIZE)-1:0]         wr_col,
  input  logic [gaas_pkg::SUB_W-1:0]               wr_data,
  input  logic                                     rd_en,
  input  logic                                     rd_zero,
  input  logic [$clog2(ALPHABET_SIZE)-1:0]         rd_col,
  output logic [ALPHABET_SIZE-1:0][gaas_pkg::SUB_W-1:0] rd_data
);

  logic [ALPHABET_SIZE-1:0][gaas_pkg::SUB_W-1:0] mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0][gaas_pkg::SUB_W-1:0] rd_data_r;

  // One byte lane is written per load.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_col][wr_row] <= wr_data;
    end
  end

  // Column read; an out-of-range database code reads as all zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_zero) begin
        rd_data_r <= '0;
      end else begin
        rd_data_r <= mem[rd_col];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/gaas_cell.sv =====
// ----------------------------------------------------------------------------
// gaas_cell
// One query position of the score column: holds the query code, the best
// score and the horizontal gap score, and updates them as the token passes.
// ----------------------------------------------------------------------------
module gaas_cell #(
  parameter int ALPHABET_SIZE = 24,
  parameter int LEN_W         = 9,
  parameter int IDX_W         = 8,
  parameter int IDX           = 0
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic [LEN_W-1:0]                              query_len,
  input  logic                                          first_col,
  input  logic [gaas_pkg::PEN_W-1:0]                    open_pen,
  input  logic [gaas_pkg::PEN_W-1:0]                    ext_pen,
  input  logic [ALPHABET_SIZE-1:0][gaas_pkg::SUB_W-1:0] column,
  input  logic                                          q_wr_en,
  input  logic [IDX_W-1:0]                              q_wr_idx,
  input  logic [gaas_pkg::CODE_W-1:0]                   q_wr_code,
  input  gaas_pkg::wave_t                               wave_i,
  output gaas_pkg::wave_t                               wave_o
);

  localparam int AW = $clog2(ALPHABET_SIZE);
  localparam logic [LEN_W-1:0] IDX_L = LEN_W'(IDX);
  localparam logic [IDX_W-1:0] IDX_I = IDX_W'(IDX);

  logic [gaas_pkg::CODE_W-1:0]        q_r;
  logic signed [gaas_pkg::SCORE_W-1:0] best_r, hgap_r;
  gaas_pkg::wave_t                    wave_r, wave_nxt;

  logic                                active;
  logic signed [gaas_pkg::CALC_W-1:0]  left, hold, op, ex, sub;
  logic signed [gaas_pkg::SCORE_W-1:0] hg, vg, hd, h;

  assign active = (IDX_L < query_len);
  assign op     = {{(gaas_pkg::CALC_W-gaas_pkg::PEN_W){1'b0}}, open_pen};
  assign ex     = {{(gaas_pkg::CALC_W-gaas_pkg::PEN_W){1'b0}}, ext_pen};

  // Cell recurrence for one database residue.
  always_comb begin
    left = first_col ? gaas_pkg::CALC_W'(wave_i.bound) : gaas_pkg::CALC_W'(best_r);
    hold = first_col ? gaas_pkg::NEG_INF : gaas_pkg::CALC_W'(hgap_r);
    if (32'(q_r) < ALPHABET_SIZE) begin
      sub = gaas_pkg::CALC_W'($signed(column[q_r[AW-1:0]]));
    end else begin
      sub = '0;
    end
    hg = gaas_pkg::clampv(gaas_pkg::max2(left - op, hold - ex));
    vg = gaas_pkg::clampv(gaas_pkg::max2(gaas_pkg::CALC_W'(wave_i.up) - op,
                                         gaas_pkg::CALC_W'(wave_i.vgap) - ex));
    hd = gaas_pkg::clampv(gaas_pkg::CALC_W'(wave_i.diag) + sub);
    h  = hd;
    if (hg > h) h = hg;
    if (vg > h) h = vg;

    // Cells past the query end hand the token on with only its bound lowered.
    wave_nxt = wave_i;
    if (active) begin
      wave_nxt.diag = left[gaas_pkg::SCORE_W-1:0];
      wave_nxt.up   = h;
      wave_nxt.vgap = vg;
    end
    wave_nxt.bound = gaas_pkg::clampv(gaas_pkg::CALC_W'(wave_i.bound) - ex);
  end

  // Token register toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r.valid <= 1'b0;
    end else begin
      wave_r.valid <= wave_i.valid;
    end
    wave_r.diag  <= wave_nxt.diag;
    wave_r.up    <= wave_nxt.up;
    wave_r.vgap  <= wave_nxt.vgap;
    wave_r.bound <= wave_nxt.bound;
  end

  // Stored column entries and the query code.
  always_ff @(posedge clk) begin
    if (q_wr_en && (q_wr_idx == IDX_I)) begin
      q_r <= q_wr_code;
    end
    if (wave_i.valid && active) begin
      best_r <= h;
      hgap_r <= hg;
    end
  end

  assign wave_o = wave_r;

endmodule

// ===== bench/global_alignment_affine_gap_score_tb.sv =====
// ----------------------------------------------------------------------------
// global_alignment_affine_gap_score_tb
// Self-checking bench for the affine-gap global alignment score engine.
// The bench loads substitution tables and queries and streams database
// residues. A behavioral score predictor computes each expected alignment
// score, and every score transaction on the output channel is compared
// against the oldest expected score. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module global_alignment_affine_gap_score_tb;

  localparam int    MAXQ      = 256;
  localparam int    ALPHA     = 24;
  localparam int    DRAIN_CYC = MAXQ + 40;
  localparam int    WDOG_MAX  = 4000;
  localparam longint SAT_LO   = -64'sd1073741824;
  localparam longint SAT_HI   = 64'sd2147483647;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_addr    = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = 24'd0;
  logic [1:0]  in_tuser    = 2'd0;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;

  global_alignment_affine_gap_score u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Predictor state: penalties, table, query and the stored score column.
  longint              open_pen;
  longint              ext_pen;
  logic signed [7:0]   sub_tab [ALPHA*ALPHA];
  logic [4:0]          qry_code [MAXQ];
  int                  qry_len;
  longint              best_col [MAXQ];
  longint              hgap_col [MAXQ];
  longint              top_bnd;
  bit                  first_col;
  bit                  qry_closed;

  // Expected scores, oldest first.
  longint              score_q[$];

  bit                  idle_en     = 1'b1;
  bit                  hold_req    = 1'b0;
  int                  err_cnt     = 0;
  int                  sent_cnt    = 0;
  int                  db_cnt      = 0;
  int                  score_cnt   = 0;
  int                  quiet_cyc   = 0;
  int                  stall_left  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat(input longint v);
    if (v < SAT_LO) return SAT_LO;
    if (v > SAT_HI) return SAT_HI;
    return v;
  endfunction

  function automatic longint maxl(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  // Advance the alignment predictor by one accepted transaction.
  task automatic predict_score(input gaas_pkg::cmd_t c, input logic [4:0] row,
                               input logic [4:0] col, input logic [7:0] sub,
                               input logic [4:0] res, input bit lst);
    longint diag, up, vg, left, hg, h, s;
    if (c == gaas_pkg::CMD_LOAD_SUB) begin
      if (row < ALPHA && col < ALPHA) sub_tab[row*ALPHA + col] = sub;
    end else if (c == gaas_pkg::CMD_LOAD_QUERY) begin
      if (qry_closed) begin
        qry_len    = 0;
        qry_closed = 1'b0;
      end
      if (qry_len < MAXQ) begin
        qry_code[qry_len] = res;
        qry_len++;
      end
      if (lst) qry_closed = 1'b1;
      first_col = 1'b1;
      top_bnd   = 0;
    end else if (c == gaas_pkg::CMD_DB_RESIDUE) begin
      diag    = top_bnd;
      vg      = SAT_LO;
      up      = first_col ? sat(-open_pen) : sat(top_bnd - ext_pen);
      top_bnd = up;
      for (int i = 0; i < qry_len; i++) begin
        if (first_col) begin
          left = sat(-open_pen - longint'(i) * ext_pen);
          hg   = SAT_LO;
        end else begin
          left = best_col[i];
          hg   = hgap_col[i];
        end
        hg = sat(maxl(left - open_pen, hg - ext_pen));
        vg = sat(maxl(up - open_pen, vg - ext_pen));
        // Codes outside the alphabet score zero.
        s  = (qry_code[i] < ALPHA && res < ALPHA) ?
             longint'(sub_tab[qry_code[i]*ALPHA + res]) : 0;
        h  = sat(diag + s);
        h  = maxl(h, maxl(hg, vg));
        best_col[i] = h;
        hgap_col[i] = hg;
        diag = left;
        up   = h;
      end
      first_col = 1'b0;
      if (lst) begin
        score_q.push_back(up);
        first_col = 1'b1;
        top_bnd   = 0;
      end
    end
  endtask

  // Offer one transaction on the input channel and wait for its acceptance.
  task automatic send_item(input gaas_pkg::cmd_t c, input logic [4:0] row,
                           input logic [4:0] col, input logic [7:0] sub,
                           input logic [4:0] res, input bit lst);
    if (idle_en && $urandom_range(0, 11) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tlast  <= lst;
    in_tdata  <= {1'b0, res, sub, col, row};
    do @(posedge clk); while (!in_tready);
    predict_score(c, row, col, sub, res, lst);
    sent_cnt++;
    if (c == gaas_pkg::CMD_DB_RESIDUE) db_cnt++;
  endtask

  task automatic send_sub(input logic [4:0] row, input logic [4:0] col, input logic [7:0] sub);
    send_item(gaas_pkg::CMD_LOAD_SUB, row, col, sub, 5'($urandom), 1'($urandom));
  endtask

  task automatic send_query(input logic [4:0] res, input bit lst);
    send_item(gaas_pkg::CMD_LOAD_QUERY, 5'($urandom), 5'($urandom), 8'($urandom), res, lst);
  endtask

  task automatic send_db(input logic [4:0] res, input bit lst);
    send_item(gaas_pkg::CMD_DB_RESIDUE, 5'($urandom), 5'($urandom), 8'($urandom), res, lst);
  endtask

  // Wait until every expected score is in and the cell row is empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input gaas_pkg::reg_idx_t idx, input logic [7:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == gaas_pkg::REG_OPEN) open_pen = val;
    else ext_pen = val;
  endtask

  task automatic set_penalties(input logic [7:0] op, input logic [7:0] ex);
    settle();
    write_reg(gaas_pkg::REG_OPEN, op);
    write_reg(gaas_pkg::REG_EXTEND, ex);
  endtask

  // Query of random codes, mostly inside the alphabet.
  task automatic load_query(input int len);
    for (int i = 0; i < len; i++)
      send_query(($urandom_range(0, 19) == 0) ? 5'($urandom_range(ALPHA, 31))
                                               : 5'($urandom_range(0, ALPHA-1)),
                 i == len - 1);
  endtask

  // Empty query straight after reset, with the reset penalties.
  task automatic test_empty_query();
    send_db(5'd3, 1'b1);
    send_db(5'd0, 1'b0);
    send_db(5'd31, 1'b0);
    send_db(5'd7, 1'b1);
    send_item(gaas_pkg::CMD_NONE, 5'd31, 5'd31, 8'hff, 5'd31, 1'b1);
  endtask

  // Whole table, plus loads with codes outside the alphabet.
  task automatic test_table_load();
    for (int r = 0; r < ALPHA; r++)
      for (int c = 0; c < ALPHA; c++)
        send_sub(5'(r), 5'(c), (r == c) ? 8'($urandom_range(1, 12)) : 8'($urandom));
    send_sub(5'd31, 5'd0, 8'h7f);
    send_sub(5'd0, 5'd24, 8'h80);
    send_sub(5'd24, 5'd31, 8'h55);
  endtask

  // Score extremes, codes outside the alphabet, restart and abandon cases.
  task automatic test_directed();
    send_sub(5'd0, 5'd0, 8'h7f);
    send_sub(5'd23, 5'd23, 8'h80);
    send_query(5'd0, 1'b0);
    send_query(5'd23, 1'b0);
    send_query(5'd31, 1'b1);
    send_db(5'd0, 1'b0);
    send_db(5'd23, 1'b0);
    send_db(5'd24, 1'b1);
    // A query load in mid-stream abandons the database sequence.
    send_db(5'd5, 1'b0);
    send_query(5'd0, 1'b1);
    send_db(5'd0, 1'b1);
    send_db(5'd0, 1'b0);
    send_db(5'd23, 1'b1);
    set_penalties(8'd0, 8'd0);
    load_query(4);
    for (int i = 0; i < 6; i++) send_db(5'($urandom_range(0, 31)), i == 5);
    set_penalties(8'd255, 8'd255);
    load_query(3);
    for (int i = 0; i < 8; i++) send_db(5'($urandom_range(0, 31)), i == 7);
  endtask

  // Query longer than the cell row: the excess residues are dropped.
  task automatic test_query_overflow();
    load_query(MAXQ + 4);
    for (int i = 0; i < 5; i++) send_db(5'($urandom_range(0, ALPHA-1)), i == 4);
  endtask

  // The receiver holds off while short sequences keep arriving.
  task automatic test_backpressure();
    load_query(2);
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_db(5'($urandom_range(0, ALPHA-1)), i % 2 == 1);
  endtask

  // Random phase under the current penalty setting.
  task automatic test_random(input int n_items);
    int k, len;
    k = 0;
    while (k < n_items) begin
      case ($urandom_range(0, 99)) inside
        [0:5]: begin
          send_sub(($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, ALPHA-1)),
                   ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, ALPHA-1)),
                   8'($urandom));
          k++;
        end
        [6:9]: begin
          len = ($urandom_range(0, 29) == 0) ? $urandom_range(32, MAXQ)
                                             : $urandom_range(1, 16);
          load_query(len);
          k += len;
        end
        [10:11]: begin
          send_item(gaas_pkg::CMD_NONE, 5'($urandom), 5'($urandom), 8'($urandom),
                    5'($urandom), 1'($urandom));
        end
        default: begin
          send_db(($urandom_range(0, 24) == 0) ? 5'($urandom_range(ALPHA, 31))
                                                : 5'($urandom_range(0, ALPHA-1)),
                  $urandom_range(0, 3) == 0);
          k++;
        end
      endcase
    end
  endtask

  // Output side: random stalls, the long hold-off, checks and the watchdog.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      score_cnt++;
      if (score_q.size() == 0) begin
        $display("%0t: unexpected score transaction, actual %0d", $time,
                 $signed(out_tdata));
        err_cnt++;
      end else begin
        if (longint'($signed(out_tdata)) != score_q[0]) begin
          $display("%0t: score mismatch, expected %0d, actual %0d", $time, score_q[0],
                   $signed(out_tdata));
          err_cnt++;
        end
        void'(score_q.pop_front());
      end
    end
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = 900;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cyc = 0;
    else quiet_cyc++;
    if (quiet_cyc >= WDOG_MAX) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cyc);
      $display("** global_alignment_affine_gap_score: FAILED **");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    open_pen   = 10;
    ext_pen    = 1;
    qry_len    = 0;
    top_bnd    = 0;
    first_col  = 1'b1;
    qry_closed = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_query();
    test_table_load();
    test_directed();
    test_query_overflow();
    test_backpressure();
    for (int p = 0; p < 4; p++) begin
      if (p == 0) set_penalties(8'd0, 8'd255);
      else if (p == 1) set_penalties(8'd255, 8'd0);
      else set_penalties(8'($urandom_range(0, 40)), 8'($urandom_range(0, 10)));
      if (p == 3) idle_en = 1'b0;
      test_random(260);
    end
    settle();
    $display("Covered %0d input transactions, %0d database residues, %0d scores checked.",
             sent_cnt, db_cnt, score_cnt);
    $display("Penalty extremes, empty and overflowing queries, restarts and back-pressure.");
    if (err_cnt == 0) begin
      $display("** global_alignment_affine_gap_score: PASSED **");
    end else begin
      $display("** global_alignment_affine_gap_score: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gaas_pkg.sv
hdl/gaas_sub_table.sv
hdl/gaas_cell.sv
hdl/global_alignment_affine_gap_score.sv
bench/global_alignment_affine_gap_score_tb.sv
